// File: src/cdq_pkg.sv
// cdq_pkg: shared types and constants for the circular deque buffer
// no dependencies; used by the channel interfaces and circular_deque_buffer
`default_nettype none

package cdq_pkg;

  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_CFG   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_LIMIT = 2'd0,
    REG_ENABLED    = 2'd1
  } reg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

endpackage

`default_nettype wire

// File: src/cdq_if.sv
// cdq_if: valid/ready channel interfaces for requests, results and configuration
// depends on cdq_pkg for field widths
`default_nettype none

interface cdq_in_if import cdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  out_value;
  logic                slot_occupied;
  logic                last;

  modport source (output valid, output status, output out_value, output slot_occupied,
                  output last, input ready);
  modport sink   (input valid, input status, input out_value, input slot_occupied,
                  input last, output ready);
endinterface

interface cdq_cfg_if import cdq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: src/cdq_ram.sv
// cdq_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/circular_deque_buffer.sv
// circular_deque_buffer: double-ended queue over a ring of slots
// depends on cdq_pkg, cdq_if (channel interfaces) and cdq_ram (slot memory)
//
// Requests on in_ch push to or pop from either end of a ring, or dump the ring.
// Each push, pop or error answers with one result whose last flag is set; a dump
// answers with one result per ring slot, front first, last set on the final one.
// Push, pop and error requests are taken one per cycle while the read stage has
// room; each result passes through the slot memory read and then the output
// register. A dump holds the input until every ring slot has been read,
// as every slot goes through the single read port of the slot memory in turn.
// Unknown opcodes are taken and give no result. Writing size_limit on cfg_ch
// empties the ring at once (occupancy is kept in flip-flops, no clearing pass);
// configuration is to be written only while the block is idle.
`default_nettype none

module circular_deque_buffer import cdq_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int WORD_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch,
  cdq_cfg_if.sink   cfg_ch
);

  // index into the ring, count/size width, stored word width
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam int SW = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;

  // control state
  state_t           state_r,     state_nxt;
  logic [NW-1:0]    ring_n_r,    ring_n_nxt;    // ring size, clipped to DEPTH
  logic             enabled_r,   enabled_nxt;
  logic [IW-1:0]    head_r,      head_nxt;
  logic [IW-1:0]    tail_r,      tail_nxt;
  logic [NW-1:0]    count_r,     count_nxt;
  logic [DEPTH-1:0] full_r,      full_nxt;      // per-slot occupancy
  logic [IW-1:0]    dump_idx_r,  dump_idx_nxt;
  logic [NW-1:0]    dump_left_r, dump_left_nxt;

  // read stage: waits on the memory read data
  logic             s1_v_r,      s1_v_nxt;
  status_t          s1_status_r, s1_status_nxt;
  logic             s1_occ_r,    s1_occ_nxt;
  logic             s1_last_r,   s1_last_nxt;

  // output register
  logic             out_v_r,      out_v_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic             out_occ_r,    out_occ_nxt;
  logic             out_last_r,   out_last_nxt;

  // memory ports
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [SW-1:0] rd_data;

  logic s1_move;
  logic issue_ok;
  logic accept;
  logic cfg_write;
  logic known_op;

  cdq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next slot towards the back, wrapping at the ring size
  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x, input logic [NW-1:0] n);
    logic [IW-1:0] r;
    if (int'(x) + 1 >= int'(n)) begin
      r = '0;
    end else begin
      r = x + IW'(1);
    end
    return r;
  endfunction

  // next slot towards the front, wrapping to the ring's top slot
  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] x, input logic [NW-1:0] n);
    logic [IW-1:0] r;
    if (x == '0) begin
      r = IW'(n - NW'(1));
    end else begin
      r = x - IW'(1);
    end
    return r;
  endfunction

  // the read stage moves on when the output register is empty or being drained
  assign s1_move  = s1_v_r && (!out_v_r || out_ch.ready);
  assign issue_ok = !s1_v_r || s1_move;

  assign in_ch.ready  = (state_r == S_IDLE) && issue_ok;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  assign known_op = (in_ch.opcode == OP_PUSH_FRONT) || (in_ch.opcode == OP_PUSH_BACK) ||
                    (in_ch.opcode == OP_POP_FRONT)  || (in_ch.opcode == OP_POP_BACK)  ||
                    (in_ch.opcode == OP_DUMP);

  assign wr_data = in_ch.push_value[SW-1:0];

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.out_value     = out_value_r;
  assign out_ch.slot_occupied = out_occ_r;
  assign out_ch.last          = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    ring_n_nxt    = ring_n_r;
    enabled_nxt   = enabled_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    full_nxt      = full_r;
    dump_idx_nxt  = dump_idx_r;
    dump_left_nxt = dump_left_r;

    // new entry for the read stage
    s1_v_nxt      = s1_v_r && !s1_move;
    s1_status_nxt = s1_status_r;
    s1_occ_nxt    = s1_occ_r;
    s1_last_nxt   = s1_last_r;

    wr_en   = 1'b0;
    wr_addr = '0;
    rd_en   = 1'b0;
    rd_addr = '0;

    // read stage into the output register; value masked unless the slot held data
    out_v_nxt      = out_v_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    if (s1_move) begin
      out_v_nxt      = 1'b1;
      out_status_nxt = s1_status_r;
      out_value_nxt  = s1_occ_r ? VALUE_W'(rd_data) : '0;
      out_occ_nxt    = s1_occ_r;
      out_last_nxt   = s1_last_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && known_op) begin
          s1_v_nxt      = 1'b1;
          s1_status_nxt = ST_OK;
          s1_occ_nxt    = 1'b0;
          s1_last_nxt   = 1'b1;
          priority if (!enabled_r) begin
            s1_status_nxt = ST_NOT_CFG;
          end else if ((in_ch.opcode == OP_PUSH_FRONT) || (in_ch.opcode == OP_PUSH_BACK)) begin
            if (count_r >= ring_n_r) begin
              s1_status_nxt = ST_OVERFLOW;
            end else begin
              wr_en = 1'b1;
              if (in_ch.opcode == OP_PUSH_FRONT) begin
                wr_addr  = ring_dec(head_r, ring_n_r);
                head_nxt = wr_addr;
              end else begin
                wr_addr  = tail_r;
                tail_nxt = ring_inc(tail_r, ring_n_r);
              end
              full_nxt[wr_addr] = 1'b1;
              count_nxt         = count_r + NW'(1);
            end
          end else if ((in_ch.opcode == OP_POP_FRONT) || (in_ch.opcode == OP_POP_BACK)) begin
            if ((count_r == '0) || (ring_n_r == '0)) begin
              s1_status_nxt = ST_UNDERFLOW;
            end else begin
              rd_en = 1'b1;
              if (in_ch.opcode == OP_POP_FRONT) begin
                rd_addr  = head_r;
                head_nxt = ring_inc(head_r, ring_n_r);
              end else begin
                rd_addr  = ring_dec(tail_r, ring_n_r);
                tail_nxt = rd_addr;
              end
              s1_occ_nxt        = full_r[rd_addr];
              full_nxt[rd_addr] = 1'b0;
              count_nxt         = count_r - NW'(1);
            end
          end else begin
            // dump: nothing issued now, the sweep starts from the front in S_DUMP
            if ((count_r == '0) || (ring_n_r == '0)) begin
              s1_status_nxt = ST_EMPTY;
            end else begin
              s1_v_nxt      = s1_v_r && !s1_move;
              s1_status_nxt = s1_status_r;
              s1_last_nxt   = s1_last_r;
              dump_idx_nxt  = head_r;
              dump_left_nxt = ring_n_r;
              state_nxt     = S_DUMP;
            end
          end
        end
      end
      S_DUMP: begin
        // one slot per cycle while the read stage has room
        if (issue_ok) begin
          rd_en         = 1'b1;
          rd_addr       = dump_idx_r;
          s1_v_nxt      = 1'b1;
          s1_status_nxt = ST_OK;
          s1_occ_nxt    = full_r[dump_idx_r];
          s1_last_nxt   = (dump_left_r == NW'(1));
          dump_idx_nxt  = ring_inc(dump_idx_r, ring_n_r);
          dump_left_nxt = dump_left_r - NW'(1);
          if (dump_left_r == NW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // the user must write configuration only while idle; the block does not enforce it
    if (cfg_write) begin
      if (cfg_ch.reg_index == REG_SIZE_LIMIT) begin
        ring_n_nxt = (int'(cfg_ch.wdata) > DEPTH) ? NW'(DEPTH) : NW'(cfg_ch.wdata);
        head_nxt   = '0;
        tail_nxt   = '0;
        count_nxt  = '0;
        full_nxt   = '0;
      end else if (cfg_ch.reg_index == REG_ENABLED) begin
        enabled_nxt = cfg_ch.wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_n_r    <= '0;
      enabled_r   <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      full_r      <= '0;
      dump_idx_r  <= '0;
      dump_left_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_n_r    <= ring_n_nxt;
      enabled_r   <= enabled_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      dump_idx_r  <= dump_idx_nxt;
      dump_left_r <= dump_left_nxt;
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_status_r  <= s1_status_nxt;
    s1_occ_r     <= s1_occ_nxt;
    s1_last_r    <= s1_last_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef SYNTH
  // element count stays within the ring
  a_count_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ring_n_r)
    else $error("element count exceeds ring size");

  // occupancy bits agree with the element count
  a_full_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    NW'($countones(full_r)) == count_r)
    else $error("occupancy bits disagree with element count");

  // a pop always reads an occupied slot
  a_pop_reads_full: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && (state_r == S_IDLE)) |-> full_r[rd_addr])
    else $error("pop from an empty slot");

  // a result without an element carries a zero value
  a_empty_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_occ_r) |-> (out_value_r == '0))
    else $error("non-zero value on a result without element");
`endif

endmodule

`default_nettype wire
